[rtl/core/protobuf_three_field_extractor_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the three-field extractor core
// Each macro expands to one labeled concurrent assertion on clk.
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_THREE_FIELD_EXTRACTOR_CORE_MACROS_SVH
`define PROTOBUF_THREE_FIELD_EXTRACTOR_CORE_MACROS_SVH

// Checked at every edge outside of reset
`define PBX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define PBX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pbx_pkg.sv]
// ----------------------------------------------------------------------------
// pbx_pkg
// Item types and wire-format codes shared by the extractor core.
// ----------------------------------------------------------------------------
package pbx_pkg;

  // One byte of message body
  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_data;
    logic       last;
  } in_item_t;

  // One decoded message
  typedef struct packed {
    logic [31:0] app_value;
    logic [31:0] depot_value;
    logic [63:0] manifest_value;
    logic        success;
    logic [2:0]  status;
  } out_item_t;

  // Parser phases
  localparam logic [1:0] PH_TAG   = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_LEN   = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MISSING = 3'd1;
  localparam logic [2:0] ST_TRUNC   = 3'd2;
  localparam logic [2:0] ST_TOOLONG = 3'd3;
  localparam logic [2:0] ST_BADWIRE = 3'd4;

  // Wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Field classes kept after a tag
  localparam logic [1:0] FC_OTHER    = 2'd0;
  localparam logic [1:0] FC_APP      = 2'd1;
  localparam logic [1:0] FC_DEPOT    = 2'd2;
  localparam logic [1:0] FC_MANIFEST = 2'd3;

  localparam logic [31:0] FIELD_APP      = 32'd1;
  localparam logic [31:0] FIELD_DEPOT    = 32'd2;
  localparam logic [31:0] FIELD_MANIFEST = 32'd3;

  // Varint group index 9 is shift 63, the last legal group
  localparam logic [3:0]  GROUP_LAST  = 4'd9;
  localparam logic [63:0] FIXED64_LEN = 64'd8;
  localparam logic [63:0] FIXED32_LEN = 64'd4;

endpackage

[rtl/core/pbx_in_reg.sv]
// ----------------------------------------------------------------------------
// pbx_in_reg
// Input register: holds one accepted byte item for the parser.
// ----------------------------------------------------------------------------
module pbx_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  pbx_pkg::in_item_t byte_item,
  input  logic             advance,
  output logic             held_valid,
  output pbx_pkg::in_item_t held_item
);
  import pbx_pkg::*;

  // Stall only while the held item cannot move on
  assign byte_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!byte_stall) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall) begin
      held_item <= byte_item;
    end
  end

endmodule

[rtl/core/pbx_parser.sv]
// ----------------------------------------------------------------------------
// pbx_parser
// Wire-format parser state: one byte per step, result built on the last item.
// ----------------------------------------------------------------------------
module pbx_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  pbx_pkg::in_item_t item,
  output pbx_pkg::out_item_t res_item
);
  import pbx_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  group, group_next;
  logic [1:0]  fclass, fclass_next;
  logic [63:0] remain, remain_next;
  logic [31:0] app, app_next;
  logic [31:0] depot, depot_next;
  logic [63:0] manifest, manifest_next;
  logic        seen_depot, seen_depot_next;
  logic        seen_manifest, seen_manifest_next;
  logic [2:0]  err, err_next;

  logic        byte_en;
  logic [5:0]  sh_amt;
  logic [63:0] acc_new;
  logic [31:0] fnum;
  logic [2:0]  wire_kind;
  logic [2:0]  st;
  logic        keep;

  assign byte_en   = step && !item.no_data && (err == ST_OK);
  assign sh_amt    = 6'({2'b00, group} * 6'd7);
  assign acc_new   = acc | ({57'd0, item.data_byte[6:0]} << sh_amt);
  assign fnum      = acc_new[34:3];
  assign wire_kind = acc_new[2:0];

  // Byte update
  always_comb begin
    phase_next         = phase;
    acc_next           = acc;
    group_next         = group;
    fclass_next        = fclass;
    remain_next        = remain;
    app_next           = app;
    depot_next         = depot;
    manifest_next      = manifest;
    seen_depot_next    = seen_depot;
    seen_manifest_next = seen_manifest;
    err_next           = err;
    if (byte_en) begin
      if (phase == PH_SKIP) begin
        remain_next = remain - 64'd1;
        if (remain == 64'd1) begin
          phase_next = PH_TAG;
          acc_next   = '0;
          group_next = '0;
        end
      end else begin
        acc_next = acc_new;
        if (item.data_byte[7]) begin
          // continuation past shift 63 is too long
          if (group == GROUP_LAST) begin
            err_next = ST_TOOLONG;
          end else begin
            group_next = group + 4'd1;
          end
        end else begin
          acc_next   = '0;
          group_next = '0;
          unique case (phase)
            PH_TAG: begin
              if (fnum == FIELD_APP) begin
                fclass_next = FC_APP;
              end else if (fnum == FIELD_DEPOT) begin
                fclass_next = FC_DEPOT;
              end else if (fnum == FIELD_MANIFEST) begin
                fclass_next = FC_MANIFEST;
              end else begin
                fclass_next = FC_OTHER;
              end
              case (wire_kind)
                WT_VARINT: phase_next = PH_VALUE;
                WT_FIXED64: begin
                  remain_next = FIXED64_LEN;
                  phase_next  = PH_SKIP;
                end
                WT_LEN: phase_next = PH_LEN;
                WT_FIXED32: begin
                  remain_next = FIXED32_LEN;
                  phase_next  = PH_SKIP;
                end
                default: err_next = ST_BADWIRE;
              endcase
            end
            PH_VALUE: begin
              case (fclass)
                FC_APP: app_next = acc_new[31:0];
                FC_DEPOT: begin
                  depot_next      = acc_new[31:0];
                  seen_depot_next = 1'b1;
                end
                FC_MANIFEST: begin
                  manifest_next      = acc_new;
                  seen_manifest_next = 1'b1;
                end
                default: ;
              endcase
              phase_next = PH_TAG;
            end
            PH_LEN: begin
              remain_next = acc_new;
              phase_next  = (acc_new != 64'd0) ? PH_SKIP : PH_TAG;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Result from the state after this byte
  always_comb begin
    if (err_next != ST_OK) begin
      st = err_next;
    end else if (phase_next != PH_TAG || group_next != 4'd0) begin
      st = ST_TRUNC;
    end else if (!(seen_depot_next && seen_manifest_next)) begin
      st = ST_MISSING;
    end else begin
      st = ST_OK;
    end
    keep                    = (st == ST_OK) || (st == ST_MISSING);
    res_item.app_value      = keep ? app_next : '0;
    res_item.depot_value    = keep ? depot_next : '0;
    res_item.manifest_value = keep ? manifest_next : '0;
    res_item.success        = (st == ST_OK);
    res_item.status         = st;
  end

  // State clears at reset and after each message
  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      phase         <= PH_TAG;
      acc           <= '0;
      group         <= '0;
      fclass        <= FC_OTHER;
      remain        <= '0;
      app           <= '0;
      depot         <= '0;
      manifest      <= '0;
      seen_depot    <= 1'b0;
      seen_manifest <= 1'b0;
      err           <= ST_OK;
    end else begin
      phase         <= phase_next;
      acc           <= acc_next;
      group         <= group_next;
      fclass        <= fclass_next;
      remain        <= remain_next;
      app           <= app_next;
      depot         <= depot_next;
      manifest      <= manifest_next;
      seen_depot    <= seen_depot_next;
      seen_manifest <= seen_manifest_next;
      err           <= err_next;
    end
  end

endmodule

[rtl/core/pbx_out_reg.sv]
// ----------------------------------------------------------------------------
// pbx_out_reg
// Result register: holds one decoded message until the receiver takes it.
// ----------------------------------------------------------------------------
module pbx_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  pbx_pkg::out_item_t load_item,
  output logic               free,
  output logic               result_valid,
  input  logic               result_stall,
  output pbx_pkg::out_item_t result_item
);
  import pbx_pkg::*;

  // Room when empty or when the held result leaves this edge
  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_item <= load_item;
    end
  end

endmodule

[rtl/core/protobuf_three_field_extractor_core.sv]
// ----------------------------------------------------------------------------
// protobuf_three_field_extractor_core
// Streams a protocol-buffer message body and returns fields 1, 2 and 3.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel: one body byte per item (no_data marks an item without a
//   byte, last marks the end of the message). result channel: one item per
//   message, sent for the item that carries last.
//   A last byte item passes through the input register, where it may wait
//   for room, and the parser then loads its result into the result register.
//   Throughput: one byte item per cycle unless byte_stall; the parser state
//   loop updates once per cycle, so messages run back to back at full rate.
//   Reset clears the parser, the input register and the result register.
//   While result_stall holds a result, byte items without last keep flowing;
//   an item with last waits in the input register until the result register
//   has room, and byte_stall goes high behind it.
// ----------------------------------------------------------------------------
module protobuf_three_field_extractor_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  pbx_pkg::in_item_t  byte_item,
  output logic               result_valid,
  input  logic               result_stall,
  output pbx_pkg::out_item_t result_item
);
  import pbx_pkg::*;

  logic      held_valid;
  in_item_t  held_item;
  logic      advance;
  logic      step;
  logic      out_free;
  out_item_t res_item;

  // A held item moves unless it needs the busy result register
  assign advance = !held_item.last || out_free;
  assign step    = held_valid && advance;

  pbx_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  pbx_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (held_item),
    .res_item (res_item)
  );

  pbx_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (step && held_item.last),
    .load_item    (res_item),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

[rtl/core/pbx_checker.sv]
// ----------------------------------------------------------------------------
// pbx_checker
// Port-level checks on the extractor core, bound to the top level.
// ----------------------------------------------------------------------------
`include "protobuf_three_field_extractor_core_macros.svh"

module pbx_checker (
  input logic               clk,
  input logic               rst,
  input logic               byte_valid,
  input logic               byte_stall,
  input pbx_pkg::in_item_t  byte_item,
  input logic               result_valid,
  input logic               result_stall,
  input pbx_pkg::out_item_t result_item
);
  import pbx_pkg::*;

  // a stalled result stays offered
  `PBX_ASSERT(a_result_held, result_valid && result_stall |=> result_valid, "result dropped while stalled")

  // a stalled byte item stays offered and unchanged
  `PBX_ASSERT(a_input_held, byte_valid && byte_stall |=> byte_valid && $stable(byte_item), "byte item changed while stalled")

  // success flag agrees with status
  `PBX_ASSERT(a_success_status, result_valid |-> (result_item.success == (result_item.status == ST_OK)), "success does not match status")

  // error results carry zeroed values
  `PBX_ASSERT(a_error_zero, result_valid && (result_item.status == ST_TRUNC || result_item.status == ST_TOOLONG || result_item.status == ST_BADWIRE) |-> (result_item.app_value == 32'd0 && result_item.depot_value == 32'd0 && result_item.manifest_value == 64'd0), "error result with nonzero value")

  // no result right after reset
  `PBX_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !result_valid, "result valid after reset")

endmodule

bind protobuf_three_field_extractor_core pbx_checker u_pbx_checker (.*);
